// ----- hdl/kdae_pkg.sv -----
// Shared types, widths and reset values for the key debounce and auto-repeat block.
`timescale 1ns / 1ps
`default_nettype none
package kdae_pkg;

    localparam int KeyW   = 8;
    localparam int TimeW  = 32;
    localparam int MsW    = 16;
    localparam int CfgAdW = 2;
    localparam int CfgDW  = 16;
    localparam int InDW   = 48;
    localparam int OutDW  = 24;

    localparam logic [MsW-1:0]  DebounceRst  = MsW'(15);
    localparam logic [MsW-1:0]  HoldRst      = MsW'(400);
    localparam logic [MsW-1:0]  RepeatRst    = MsW'(180);
    localparam logic [KeyW-1:0] RepeatKeyRst = '0;

    typedef enum logic [CfgAdW-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_HOLD       = 2'd1,
        CFG_REPEAT     = 2'd2,
        CFG_REPEAT_KEY = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [MsW-1:0]  settle_ms;
        logic [MsW-1:0]  hold_ms;
        logic [MsW-1:0]  interval_ms;
        logic [KeyW-1:0] repeat_key;
    } t_cfg;

    typedef struct packed {
        logic [KeyW-1:0]  raw_last_a;
        logic [KeyW-1:0]  raw_last_b;
        logic [TimeW-1:0] raw_change_time;
        logic [KeyW-1:0]  stable_prev_a;
        logic [KeyW-1:0]  stable_prev_b;
        logic [KeyW-1:0]  slot0_code;
        logic [KeyW-1:0]  slot1_code;
        logic [TimeW-1:0] slot0_next;
        logic [TimeW-1:0] slot1_next;
        logic [KeyW-1:0]  emitted_a;
        logic [KeyW-1:0]  emitted_b;
    } t_state;

    typedef struct packed {
        logic [KeyW-1:0] event_key_a;
        logic [KeyW-1:0] event_key_b;
        logic            events_changed;
        logic            settled;
    } t_result;

endpackage
`default_nettype wire

// ----- hdl/kdae_cfg.sv -----
// Configuration register bank for the key debounce and auto-repeat block.
`timescale 1ns / 1ps
`default_nettype none
module kdae_cfg
    import kdae_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CfgAdW-1:0] i_cfg_addr,
    input  wire logic [CfgDW-1:0]  i_cfg_wdata,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ms   <= DebounceRst;
            r_cfg.hold_ms     <= HoldRst;
            r_cfg.interval_ms <= RepeatRst;
            r_cfg.repeat_key  <= RepeatKeyRst;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEBOUNCE:   r_cfg.settle_ms   <= i_cfg_wdata;
                CFG_HOLD:       r_cfg.hold_ms     <= i_cfg_wdata;
                CFG_REPEAT:     r_cfg.interval_ms <= i_cfg_wdata;
                CFG_REPEAT_KEY: r_cfg.repeat_key  <= i_cfg_wdata[KeyW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- hdl/kdae_eval.sv -----
// Single-pass scan evaluation: debounce, press detection, repeat slots, change flag.
`timescale 1ns / 1ps
`default_nettype none
module kdae_eval
    import kdae_pkg::*;
(
    input  wire t_cfg              i_cfg,
    input  wire t_state            i_state,
    input  wire logic [TimeW-1:0]  i_now_ms,
    input  wire logic [KeyW-1:0]   i_raw_key_a,
    input  wire logic [KeyW-1:0]   i_raw_key_b,
    output t_state                 o_state,
    output t_result                o_result
);

    logic             raw_changed;
    logic [TimeW-1:0] change_time;
    logic [TimeW-1:0] elapsed;
    logic             settled;
    logic             press0, press1;
    logic             rep_ok0, rep_ok1;
    logic [KeyW-1:0]  e0, e1;
    logic [KeyW-1:0]  c0, c1;
    logic [TimeW-1:0] t0, t1;
    logic [TimeW-1:0] hold_at, repeat_at;
    logic [TimeW-1:0] late0, late1;
    t_state           nxt;

    assign raw_changed = (i_raw_key_a != i_state.raw_last_a) ||
                         (i_raw_key_b != i_state.raw_last_b);
    assign change_time = raw_changed ? i_now_ms : i_state.raw_change_time;
    assign elapsed     = i_now_ms - change_time;
    assign settled     = elapsed >= {{(TimeW-MsW){1'b0}}, i_cfg.settle_ms};

    assign hold_at   = i_now_ms + {{(TimeW-MsW){1'b0}}, i_cfg.hold_ms};
    assign repeat_at = i_now_ms + {{(TimeW-MsW){1'b0}}, i_cfg.interval_ms};

    // A code presses when it was absent from the previous settled pair
    assign press0 = (i_raw_key_a != '0) && (i_raw_key_a != i_state.stable_prev_a) &&
                    (i_raw_key_a != i_state.stable_prev_b);
    assign press1 = (i_raw_key_b != '0) && (i_raw_key_b != i_state.stable_prev_a) &&
                    (i_raw_key_b != i_state.stable_prev_b);
    assign rep_ok0 = (i_cfg.repeat_key != '0) && (i_raw_key_a == i_cfg.repeat_key);
    assign rep_ok1 = (i_cfg.repeat_key != '0) && (i_raw_key_b == i_cfg.repeat_key);

    always_comb begin
        nxt                 = i_state;
        nxt.raw_last_a      = i_raw_key_a;
        nxt.raw_last_b      = i_raw_key_b;
        nxt.raw_change_time = change_time;
        e0 = '0;
        e1 = '0;
        c0 = i_state.slot0_code;
        c1 = i_state.slot1_code;
        t0 = i_state.slot0_next;
        t1 = i_state.slot1_next;
        late0 = '0;
        late1 = '0;

        // Press events, slot 0 follows key a and slot 1 follows key b
        if (press0) begin
            e0 = i_raw_key_a;
            if (rep_ok0) begin
                c0 = i_raw_key_a;
                t0 = hold_at;
            end else if (c0 == i_raw_key_a) begin
                c0 = '0;
            end
        end
        if (press1) begin
            if (e0 == '0) e0 = i_raw_key_b; else e1 = i_raw_key_b;
            if (rep_ok1) begin
                c1 = i_raw_key_b;
                t1 = hold_at;
            end else if (c1 == i_raw_key_b) begin
                c1 = '0;
            end
        end

        // Repeat events; wrap-safe deadline test on the sign of the difference
        late0 = i_now_ms - t0;
        if (!((e0 != '0) && (e1 != '0)) && (c0 != '0)) begin
            if ((c0 == i_raw_key_a) || (c0 == i_raw_key_b)) begin
                if ((i_cfg.repeat_key != '0) && (c0 == i_cfg.repeat_key) &&
                    !late0[TimeW-1]) begin
                    if (e0 == '0) e0 = c0; else e1 = c0;
                    t0 = repeat_at;
                end
            end else begin
                c0 = '0;
            end
        end
        late1 = i_now_ms - t1;
        if (!((e0 != '0) && (e1 != '0)) && (c1 != '0)) begin
            if ((c1 == i_raw_key_a) || (c1 == i_raw_key_b)) begin
                if ((i_cfg.repeat_key != '0) && (c1 == i_cfg.repeat_key) &&
                    !late1[TimeW-1]) begin
                    if (e0 == '0) e0 = c1; else e1 = c1;
                    t1 = repeat_at;
                end
            end else begin
                c1 = '0;
            end
        end

        o_result.event_key_a    = '0;
        o_result.event_key_b    = '0;
        o_result.events_changed = 1'b0;
        o_result.settled        = settled;
        if (settled) begin
            o_result.event_key_a    = e0;
            o_result.event_key_b    = e1;
            o_result.events_changed = (e0 != i_state.emitted_a) ||
                                      (e1 != i_state.emitted_b);
            nxt.slot0_code    = c0;
            nxt.slot1_code    = c1;
            nxt.slot0_next    = t0;
            nxt.slot1_next    = t1;
            nxt.emitted_a     = e0;
            nxt.emitted_b     = e1;
            nxt.stable_prev_a = i_raw_key_a;
            nxt.stable_prev_b = i_raw_key_b;
        end
        o_state = nxt;
    end

endmodule
`default_nettype wire

// ----- hdl/key_debounce_autorepeat_events_core.sv -----
// Top level of the key debounce and auto-repeat event block.
// Each accepted scan gives exactly one result transfer. A scan is held in an
// input register, evaluated combinationally against the debounce and
// repeat-slot state, and placed in an output register; one scan is taken
// every cycle while the output is drained. The rate is set by the
// compare-and-update pass that carries the key state from one scan to the
// next. Input tdata holds now_ms, raw_key_a, raw_key_b from the lowest bit
// up; output tdata holds event_key_a, event_key_b, events_changed, settled.
// Configuration writes take effect on the next scan; the user must make them
// while no scan is in flight, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module key_debounce_autorepeat_events_core
    import kdae_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CfgAdW-1:0] i_cfg_addr,
    input  wire logic [CfgDW-1:0]  i_cfg_wdata,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // now_ms[31:0], raw_key_a[39:32], raw_key_b[47:40]
    input  wire logic [InDW-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // event_key_a[7:0], event_key_b[15:8], events_changed[16], settled[17], zero fill
    output logic [OutDW-1:0]       o_m_tdata
);

    t_cfg             cfg;
    t_state           r_state, n_state;
    t_result          result;
    logic             r_in_vld;
    logic [InDW-1:0]  r_in_data;
    logic             r_out_vld;
    t_result          r_out;
    logic             out_adv;
    logic             eval_en;

    kdae_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    kdae_eval u_eval (
        .i_cfg       (cfg),
        .i_state     (r_state),
        .i_now_ms    (r_in_data[TimeW-1:0]),
        .i_raw_key_a (r_in_data[TimeW+KeyW-1:TimeW]),
        .i_raw_key_b (r_in_data[TimeW+2*KeyW-1:TimeW+KeyW]),
        .o_state     (n_state),
        .o_result    (result)
    );

    assign out_adv    = !r_out_vld || i_m_tready;
    assign eval_en    = r_in_vld && out_adv;
    assign o_s_tready = !r_in_vld || out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (o_s_tready) r_in_vld <= i_s_tvalid;
            if (out_adv) r_out_vld <= r_in_vld;
            // Advance the key state only when the scan moves to the output
            if (eval_en) r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) r_in_data <= i_s_tdata;
        if (eval_en) r_out <= result;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OutDW-2*KeyW-2){1'b0}}, r_out.settled, r_out.events_changed,
                         r_out.event_key_b, r_out.event_key_a};

endmodule
`default_nettype wire
